/* hw/rtl/mwu_pkg.sv */
// Package for the maze wall union engine: payload structs, status and state codes,
// default sizes. No dependencies.
`timescale 1ns / 1ps

package mwu_pkg;

  // Grid size and configuration defaults
  localparam int unsigned MAX_SIDE_DEF = 64;
  localparam int unsigned SIDE_W       = 7;
  localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd8;
  localparam int unsigned COUNT_OUT_W  = 13;

  // Operation and direction codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_WALL  = 1'b1;
  localparam logic DIR_RIGHT = 1'b0;
  localparam logic DIR_BELOW = 1'b1;

  typedef enum logic [1:0] {
    STAT_KEPT    = 2'd0,
    STAT_REMOVED = 2'd1,
    STAT_INVALID = 2'd2,
    STAT_START   = 2'd3
  } mwu_status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT_N,
    ST_INIT,
    ST_CHECK,
    ST_RD_A,
    ST_RD_B,
    ST_CMP,
    ST_SWEEP,
    ST_SWEEP_END
  } mwu_state_e;

  typedef struct packed {
    logic       op;
    logic [5:0] wall_row;
    logic [5:0] wall_col;
    logic       wall_dir;
  } mwu_in_t;

  typedef struct packed {
    mwu_status_e             status;
    logic [COUNT_OUT_W-1:0]  chambers_left;
    logic                    done_res;
  } mwu_res_t;

endpackage

/* hw/rtl/mwu_ram.sv */
// Generic single write, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mwu_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/maze_wall_union_engine.sv */
// Maze wall union engine top level: sequencer, label store and result register.
// Depends on mwu_pkg and mwu_ram.
//
//   channel  | direction | handshake                     | payload
//   ---------+-----------+-------------------------------+-------------------
//   command  | in        | start high, busy low          | in_i  (mwu_in_t)
//   result   | out       | result_strobe_o, one cycle    | res_o (mwu_res_t)
//   config   | in        | cfg_valid_i and cfg_ready_o   | cfg_data_i (side)
//
// One transaction at a time; busy stays high until its result is shown.
// Start: writes every cell's index as its label, one label write per cycle.
// Wall: ends at the check if invalid, at the label compare if kept, and after the
// relabel sweep if removed, reading one label a cycle via the single RAM read port.
// Reset clears the sequencer, chamber count and started flag; the label memory is
// not cleared, every start rewrites it. The receiver cannot stall results.
`timescale 1ns / 1ps

module maze_wall_union_engine #(
  parameter int unsigned MAX_SIDE = mwu_pkg::MAX_SIDE_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  mwu_pkg::mwu_in_t                in_i,
  output logic                            result_strobe_o,
  output mwu_pkg::mwu_res_t               res_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mwu_pkg::SIDE_W-1:0]      cfg_data_i
);

  import mwu_pkg::*;

  localparam int unsigned CELLS = MAX_SIDE * MAX_SIDE;
  localparam int unsigned LBL_W = $clog2(CELLS);
  localparam int unsigned CNT_W = $clog2(CELLS + 1);
  localparam int unsigned GS_W  = $clog2(MAX_SIDE + 1);
  localparam int unsigned CMP_W = (GS_W > SIDE_W) ? GS_W : SIDE_W;
  localparam int unsigned PRD_W = 2 * CMP_W;

  mwu_state_e        state_q, state_d;
  logic [SIDE_W-1:0] side_q;
  logic [GS_W-1:0]   grid_side_q, grid_side_d;
  logic [CNT_W-1:0]  cells_q, cells_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              started_q, started_d;
  logic              strobe_q, strobe_d;
  mwu_res_t          res_q, res_d;
  mwu_in_t           cmd_q, cmd_d;
  logic [LBL_W-1:0]  a_q, a_d;
  logic [LBL_W-1:0]  b_q, b_d;
  logic [LBL_W-1:0]  la_q, la_d;
  logic [LBL_W-1:0]  lb_q, lb_d;
  logic [LBL_W-1:0]  idx_q, idx_d;
  logic [LBL_W-1:0]  widx_q;
  logic              sweep_vld_q;

  // Label memory port signals
  logic              ram_we;
  logic [LBL_W-1:0]  ram_waddr;
  logic [LBL_W-1:0]  ram_wdata;
  logic [LBL_W-1:0]  ram_raddr;
  logic [LBL_W-1:0]  ram_rdata;

  // Address arithmetic and the shared label comparator
  logic [CMP_W-1:0]  side_x, max_x, gs_x, row_x, col_x;
  logic [GS_W-1:0]   side_clamped;
  logic [PRD_W-1:0]  row_prod;
  logic [PRD_W-1:0]  gs_sq;
  logic              wall_out;
  logic [LBL_W-1:0]  cmp_ref;
  logic              lbl_eq;
  logic [LBL_W-1:0]  last_idx;

  mwu_ram #(
    .WIDTH (LBL_W),
    .DEPTH (CELLS)
  ) u_label_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Side clamp: 0 counts as 1, anything above the maximum as the maximum
  assign side_x = CMP_W'(side_q);
  assign max_x  = CMP_W'(MAX_SIDE);
  always_comb begin
    if (side_x == '0) begin
      side_clamped = GS_W'(1);
    end else if (side_x > max_x) begin
      side_clamped = GS_W'(MAX_SIDE);
    end else begin
      side_clamped = GS_W'(side_x);
    end
  end

  // Wall position checks and cell index of the first cell
  assign gs_x     = CMP_W'(grid_side_q);
  assign row_x    = CMP_W'(cmd_q.wall_row);
  assign col_x    = CMP_W'(cmd_q.wall_col);
  assign row_prod = PRD_W'(row_x) * PRD_W'(gs_x);
  assign gs_sq    = PRD_W'(gs_x) * PRD_W'(gs_x);
  assign wall_out = (row_x >= gs_x) || (col_x >= gs_x) ||
                    ((cmd_q.wall_dir == DIR_BELOW) ? (row_x + 1'b1 >= gs_x)
                                                   : (col_x + 1'b1 >= gs_x));

  assign cmp_ref  = (state_q == ST_CMP) ? la_q : lb_q;
  assign lbl_eq   = (ram_rdata == cmp_ref);
  assign last_idx = LBL_W'(cells_q - 1'b1);

  assign cfg_ready_o = 1'b1;

  // Sequencer: next state, memory control and result
  always_comb begin
    state_d     = state_q;
    grid_side_d = grid_side_q;
    cells_d     = cells_q;
    count_d     = count_q;
    started_d   = started_q;
    strobe_d    = 1'b0;
    res_d       = res_q;
    cmd_d       = cmd_q;
    a_d         = a_q;
    b_d         = b_q;
    la_d        = la_q;
    lb_d        = lb_q;
    idx_d       = idx_q;
    ram_raddr   = idx_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = idx_q;

    // Relabel write for the label read in the previous sweep cycle
    if (sweep_vld_q && lbl_eq) begin
      ram_we    = 1'b1;
      ram_waddr = widx_q;
      ram_wdata = la_q;
    end

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_d = in_i;
          if (in_i.op == OP_START) begin
            grid_side_d = side_clamped;
            state_d     = ST_INIT_N;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_INIT_N: begin
        cells_d = CNT_W'(gs_sq);
        idx_d   = '0;
        state_d = ST_INIT;
      end
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = idx_q;
        idx_d     = idx_q + 1'b1;
        if (idx_q == last_idx) begin
          count_d   = cells_q;
          started_d = 1'b1;
          strobe_d  = 1'b1;
          res_d     = '{status: STAT_START, chambers_left: COUNT_OUT_W'(cells_q),
                        done_res: (cells_q == CNT_W'(1))};
          state_d   = ST_IDLE;
        end
      end
      ST_CHECK: begin
        if (!started_q || wall_out) begin
          strobe_d = 1'b1;
          res_d    = '{status: STAT_INVALID, chambers_left: COUNT_OUT_W'(count_q),
                       done_res: (count_q == CNT_W'(1))};
          state_d  = ST_IDLE;
        end else begin
          a_d     = LBL_W'(row_prod + PRD_W'(col_x));
          b_d     = LBL_W'(row_prod + PRD_W'(col_x)) +
                    ((cmd_q.wall_dir == DIR_BELOW) ? LBL_W'(grid_side_q) : LBL_W'(1));
          state_d = ST_RD_A;
        end
      end
      ST_RD_A: begin
        ram_raddr = a_q;
        state_d   = ST_RD_B;
      end
      ST_RD_B: begin
        ram_raddr = b_q;
        la_d      = ram_rdata;
        state_d   = ST_CMP;
      end
      ST_CMP: begin
        if (lbl_eq) begin
          strobe_d = 1'b1;
          res_d    = '{status: STAT_KEPT, chambers_left: COUNT_OUT_W'(count_q),
                       done_res: (count_q == CNT_W'(1))};
          state_d  = ST_IDLE;
        end else begin
          lb_d    = ram_rdata;
          idx_d   = '0;
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        ram_raddr = idx_q;
        idx_d     = idx_q + 1'b1;
        if (idx_q == last_idx) begin
          state_d = ST_SWEEP_END;
        end
      end
      ST_SWEEP_END: begin
        if (count_q != '0) begin
          count_d = count_q - 1'b1;
        end
        strobe_d = 1'b1;
        res_d    = '{status: STAT_REMOVED, chambers_left: COUNT_OUT_W'(count_d),
                     done_res: (count_d == CNT_W'(1))};
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      side_q      <= SIDE_RESET;
      grid_side_q <= GS_W'(1);
      cells_q     <= CNT_W'(1);
      count_q     <= '0;
      started_q   <= 1'b0;
      strobe_q    <= 1'b0;
      sweep_vld_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      grid_side_q <= grid_side_d;
      cells_q     <= cells_d;
      count_q     <= count_d;
      started_q   <= started_d;
      strobe_q    <= strobe_d;
      sweep_vld_q <= (state_q == ST_SWEEP);
      if (cfg_valid_i && cfg_ready_o) begin
        side_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    cmd_q  <= cmd_d;
    a_q    <= a_d;
    b_q    <= b_d;
    la_q   <= la_d;
    lb_q   <= lb_d;
    idx_q  <= idx_d;
    widx_q <= idx_q;
  end

  assign busy            = (state_q != ST_IDLE);
  assign result_strobe_o = strobe_q;
  assign res_o           = res_q;

endmodule

/* hw/rtl/mwu_checker.sv */
// Port-level checker for the maze wall union engine, bound to the top level.
// Depends on mwu_pkg.
`timescale 1ns / 1ps

module mwu_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              result_strobe_o,
  input mwu_pkg::mwu_res_t res_o
);

  import mwu_pkg::*;

  // An accepted transaction always makes the engine busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("engine not busy after accepting a transaction");

  // A result is only shown once the engine has gone idle
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> !busy)
    else $error("result shown while busy");

  // Busy only drops together with a result
  a_fall_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_strobe_o)
    else $error("busy dropped without a result");

  // Completion flag agrees with the reported chamber count
  a_done_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> (res_o.done_res == (res_o.chambers_left == 13'd1)))
    else $error("done flag disagrees with chamber count");

endmodule

bind maze_wall_union_engine mwu_checker u_mwu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .result_strobe_o (result_strobe_o),
  .res_o           (res_o)
);

/* tb/sv/tb.sv */
// Self-checking bench for maze_wall_union_engine: directed and random start/wall
// commands with side changes between mazes, checked against an in-bench label model.
// Depends on mwu_pkg and the engine RTL.
`timescale 1ns / 1ps

module tb;
  import mwu_pkg::*;

  localparam int unsigned MAX_CELLS = MAX_SIDE_DEF * MAX_SIDE_DEF;

  // Clock, reset and engine ports
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start       = 1'b0;
  logic              busy;
  mwu_in_t           in_i        = '0;
  logic              result_strobe_o;
  mwu_res_t          res_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [SIDE_W-1:0] cfg_data_i  = '0;

  maze_wall_union_engine dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .in_i            (in_i),
    .result_strobe_o (result_strobe_o),
    .res_o           (res_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Pending work: either a command or a side write
  typedef struct {
    bit                is_side;
    logic [SIDE_W-1:0] side;
    mwu_in_t           cmd;
  } job_t;

  job_t     work_q[$];
  mwu_res_t chamber_reports_q[$];
  int       fail_count = 0;
  int       cmds_taken = 0;

  // Maze state as the engine should hold it
  logic [SIDE_W-1:0] side_reg = SIDE_RESET;
  int unsigned       maze_side = 1;
  int unsigned       cell_chamber[MAX_CELLS];
  int unsigned       chamber_total = 0;
  bit                maze_open = 1'b0;

  function automatic void queue_cmd(mwu_in_t c);
    job_t j;
    j.is_side = 1'b0;
    j.side    = '0;
    j.cmd     = c;
    work_q.push_back(j);
  endfunction

  function automatic void queue_side(logic [SIDE_W-1:0] s);
    job_t j;
    j.is_side = 1'b1;
    j.side    = s;
    j.cmd     = '0;
    work_q.push_back(j);
  endfunction

  // Apply one command to the maze state and return the report it should give
  function automatic mwu_res_t apply_wall_cmd(mwu_in_t c);
    mwu_res_t    r;
    mwu_status_e st;
    int unsigned s, r2, c2, a, b, la, lb, i;
    if (c.op == OP_START) begin
      s = side_reg;
      if (s < 1) s = 1;
      if (s > MAX_SIDE_DEF) s = MAX_SIDE_DEF;
      maze_side = s;
      for (i = 0; i < s * s; i++) cell_chamber[i] = i;
      chamber_total = s * s;
      maze_open = 1'b1;
      st = STAT_START;
    end else if (!maze_open) begin
      st = STAT_INVALID;
    end else begin
      r2 = c.wall_row;
      c2 = c.wall_col;
      if (c.wall_dir == DIR_RIGHT) c2++;
      else r2++;
      if (c.wall_row >= maze_side || c.wall_col >= maze_side ||
          r2 >= maze_side || c2 >= maze_side) begin
        st = STAT_INVALID;
      end else begin
        a  = c.wall_row * maze_side + c.wall_col;
        b  = r2 * maze_side + c2;
        la = cell_chamber[a];
        lb = cell_chamber[b];
        if (la == lb) begin
          st = STAT_KEPT;
        end else begin
          // merge: second chamber takes the first chamber's label
          for (i = 0; i < maze_side * maze_side; i++)
            if (cell_chamber[i] == lb) cell_chamber[i] = la;
          if (chamber_total > 0) chamber_total--;
          st = STAT_REMOVED;
        end
      end
    end
    r.status        = st;
    r.chambers_left = chamber_total[COUNT_OUT_W-1:0];
    r.done_res      = (chamber_total == 1);
    return r;
  endfunction

  // Driver: presents queued commands and side writes, with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    logic              nxt_start, nxt_cfg;
    mwu_in_t           nxt_cmd;
    logic [SIDE_W-1:0] nxt_side;
    bit                quiet;
    if (!rst_ni) begin
      start       <= 1'b0;
      cfg_valid_i <= 1'b0;
      in_i        <= '0;
      cfg_data_i  <= '0;
    end else begin
      nxt_start = start;
      nxt_cfg   = cfg_valid_i;
      nxt_cmd   = in_i;
      nxt_side  = cfg_data_i;
      // command transaction
      if (start && !busy) begin
        chamber_reports_q.push_back(apply_wall_cmd(in_i));
        work_q.delete(0);
        cmds_taken++;
        nxt_start = 1'b0;
      end
      // side write transaction
      if (cfg_valid_i && cfg_ready_o) begin
        side_reg = cfg_data_i;
        work_q.delete(0);
        nxt_cfg = 1'b0;
      end
      if (!nxt_start) nxt_cmd = mwu_in_t'(14'($urandom));
      if (!nxt_cfg) nxt_side = SIDE_W'($urandom);
      if (!nxt_start && !nxt_cfg && work_q.size() != 0) begin
        // no random gaps through the middle of the run (commands 50 to 95)
        quiet = (cmds_taken < 50 || cmds_taken > 95) && ($urandom_range(0, 99) < 27);
        if (!quiet) begin
          if (!work_q[0].is_side) begin
            nxt_start = 1'b1;
            nxt_cmd   = work_q[0].cmd;
          end else if (chamber_reports_q.size() == 0 && !start) begin
            nxt_cfg  = 1'b1;
            nxt_side = work_q[0].side;
          end
        end
      end
      start       <= nxt_start;
      cfg_valid_i <= nxt_cfg;
      in_i        <= nxt_cmd;
      cfg_data_i  <= nxt_side;
    end
  end

  // Monitor: each strobed report against the oldest expectation
  always @(posedge clk_i) begin
    mwu_res_t want;
    if (rst_ni && result_strobe_o) begin
      if (chamber_reports_q.size() == 0) begin
        $error("unexpected report: status %0d chambers_left %0d", res_o.status,
               res_o.chambers_left);
        fail_count++;
      end else begin
        want = chamber_reports_q.pop_front();
        if (res_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_o.status);
          fail_count++;
        end
        if (res_o.chambers_left !== want.chambers_left) begin
          $error("chambers_left: expected %0d, got %0d", want.chambers_left,
                 res_o.chambers_left);
          fail_count++;
        end
        if (res_o.done_res !== want.done_res) begin
          $error("done_res: expected %0d, got %0d", want.done_res, res_o.done_res);
          fail_count++;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    mwu_in_t           walls[$];
    mwu_in_t           tmp;
    logic [SIDE_W-1:0] s;
    int unsigned       made, pick, eff, nwalls, r, c, i, j;

    // walls before any maze exists
    queue_cmd({OP_WALL, 6'd0, 6'd0, DIR_RIGHT});
    queue_cmd({OP_WALL, 6'd63, 6'd63, DIR_BELOW});
    // side zero behaves as one: single chamber, every wall invalid
    queue_side(7'd0);
    queue_cmd({OP_START, 6'd0, 6'd0, DIR_RIGHT});
    queue_cmd({OP_WALL, 6'd0, 6'd0, DIR_RIGHT});
    // 2x2 maze: merges, kept walls, walls off the grid, restart with junk fields
    queue_side(7'd2);
    queue_cmd({OP_START, 6'd0, 6'd0, DIR_RIGHT});
    queue_cmd({OP_WALL, 6'd0, 6'd0, DIR_RIGHT});
    queue_cmd({OP_WALL, 6'd0, 6'd0, DIR_RIGHT});
    queue_cmd({OP_WALL, 6'd0, 6'd0, DIR_BELOW});
    queue_cmd({OP_WALL, 6'd1, 6'd0, DIR_RIGHT});
    queue_cmd({OP_WALL, 6'd0, 6'd1, DIR_BELOW});
    queue_cmd({OP_WALL, 6'd1, 6'd1, DIR_RIGHT});
    queue_cmd({OP_WALL, 6'd1, 6'd1, DIR_BELOW});
    queue_cmd({OP_WALL, 6'd63, 6'd63, DIR_RIGHT});
    queue_cmd({OP_START, 6'd63, 6'd63, DIR_BELOW});
    // oversized side clamps to the full grid
    queue_side(7'd127);
    queue_cmd({OP_START, 6'd0, 6'd0, DIR_RIGHT});
    queue_cmd({OP_WALL, 6'd63, 6'd62, DIR_RIGHT});
    queue_cmd({OP_WALL, 6'd62, 6'd63, DIR_BELOW});
    queue_cmd({OP_WALL, 6'd63, 6'd63, DIR_RIGHT});
    queue_cmd({OP_WALL, 6'd0, 6'd63, DIR_RIGHT});
    // new side has no effect until the next start
    queue_side(7'd3);
    queue_cmd({OP_WALL, 6'd10, 6'd10, DIR_RIGHT});
    queue_cmd({OP_WALL, 6'd2, 6'd2, DIR_BELOW});
    queue_cmd({OP_START, 6'd0, 6'd0, DIR_RIGHT});

    // random mazes, one side write per maze
    made = 0;
    while (made < 110) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) s = ($urandom_range(0, 1) != 0) ? 7'd64 : SIDE_W'($urandom_range(65, 127));
      else if (pick == 1) s = SIDE_W'($urandom_range(0, 1));
      else if (pick < 13) s = SIDE_W'($urandom_range(2, 5));
      else s = SIDE_W'($urandom_range(6, 8));
      eff = (s == 0) ? 1 : (s > MAX_SIDE_DEF) ? MAX_SIDE_DEF : s;
      queue_side(s);
      queue_cmd({OP_START, 6'($urandom), 6'($urandom), 1'($urandom)});
      made++;

      walls.delete();
      if (eff >= 2 && eff <= 5) begin
        // every wall of the grid once, shuffled; a random wall or start may take a wall's place
        for (r = 0; r < eff; r++)
          for (c = 0; c < eff; c++) begin
            if (c + 1 < eff) walls.push_back({OP_WALL, 6'(r), 6'(c), DIR_RIGHT});
            if (r + 1 < eff) walls.push_back({OP_WALL, 6'(r), 6'(c), DIR_BELOW});
          end
        for (i = walls.size() - 1; i > 0; i--) begin
          j        = $urandom_range(0, i);
          tmp      = walls[i];
          walls[i] = walls[j];
          walls[j] = tmp;
        end
      end else begin
        // random walls on the single-cell grid or a larger one; few walls on the full grid, it is slow
        nwalls = (eff == 1) ? 3 : (eff > 8) ? 7 : 20;
        for (i = 0; i < nwalls; i++)
          walls.push_back({OP_WALL, 6'($urandom_range(0, eff - 1)),
                           6'($urandom_range(0, eff - 1)), 1'($urandom)});
      end

      foreach (walls[k]) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) queue_cmd({OP_WALL, 6'($urandom), 6'($urandom), 1'($urandom)});
        else if (pick < 15) queue_cmd({OP_START, 6'($urandom), 6'($urandom), 1'($urandom)});
        else queue_cmd(walls[k]);
        made++;
      end
    end

    while (work_q.size() != 0 || chamber_reports_q.size() != 0 || start || cfg_valid_i)
      @(posedge clk_i);
    // longest merge sweep, to catch any late stray report
    repeat (4200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Reset: asserted at time zero, released once
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Watchdog
  initial begin
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/mwu_pkg.sv
hw/rtl/mwu_ram.sv
hw/rtl/maze_wall_union_engine.sv
hw/rtl/mwu_checker.sv
tb/sv/tb.sv
